### hdl/quaternion_frame_rotation_unit_defines.svh
// ---------------------------------------------------------------------------
// Quaternion frame rotation unit assertion macros
// Concurrent check macros shared by the rotation unit; they compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_FRAME_ROTATION_UNIT_DEFINES_SVH
`define QUATERNION_FRAME_ROTATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define QFR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qfr implication check failed");
`define QFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qfr next-cycle check failed");
`else
`define QFR_ASSERT_IMPL(name, ante, cons)
`define QFR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### hdl/qfr_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion frame rotation package
// Widths, fixed-point constants and shared types of the rotation unit.
// ---------------------------------------------------------------------------
package qfr_pkg;

  localparam int QW    = 16;
  localparam int VW    = 32;
  localparam int EW    = 33;
  localparam int PW    = EW + VW;
  localparam int SW    = PW + 2;
  localparam int FRAC  = 27;
  localparam int QOUTW = SW - FRAC;

  localparam logic signed [EW-1:0] ENTRY_HALF = EW'(64'sd134217728);
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sd67108864);
  localparam logic signed [VW-1:0] SAT_MAX    = 32'sh7fffffff;
  localparam logic signed [VW-1:0] SAT_MIN    = 32'sh80000000;

  localparam logic ACT_BODY_TO_EARTH = 1'b0;
  localparam logic ACT_EARTH_TO_BODY = 1'b1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } qfr_en_t;

  typedef struct packed {
    logic signed [VW-1:0] z;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] x;
  } qfr_vec_t;

  typedef struct packed {
    logic signed [EW-1:0] m2;
    logic signed [EW-1:0] m1;
    logic signed [EW-1:0] m0;
  } qfr_row_t;

endpackage

### hdl/qfr_matrix.sv
// ---------------------------------------------------------------------------
// Quaternion frame rotation matrix builder
// Two-stage pipeline: registered quaternion products, then the nine matrix
// entries arranged as rows or as columns for the three dot-product lanes.
// ---------------------------------------------------------------------------
module qfr_matrix (
  input  logic                        clk,
  input  qfr_pkg::qfr_en_t            en,
  input  logic                        action,
  input  logic signed [qfr_pkg::QW-1:0] quat_w,
  input  logic signed [qfr_pkg::QW-1:0] quat_x,
  input  logic signed [qfr_pkg::QW-1:0] quat_y,
  input  logic signed [qfr_pkg::QW-1:0] quat_z,
  input  qfr_pkg::qfr_vec_t           vec,
  output qfr_pkg::qfr_row_t           row_x,
  output qfr_pkg::qfr_row_t           row_y,
  output qfr_pkg::qfr_row_t           row_z,
  output qfr_pkg::qfr_vec_t           vec_out
);
  import qfr_pkg::*;

  localparam int PRW = 2 * QW;

  logic signed [PRW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic                  action1;
  qfr_vec_t              vec1;

  logic signed [EW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  qfr_row_t             row_x_next, row_y_next, row_z_next;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      xx      <= PRW'(quat_x) * PRW'(quat_x);
      yy      <= PRW'(quat_y) * PRW'(quat_y);
      zz      <= PRW'(quat_z) * PRW'(quat_z);
      xy      <= PRW'(quat_x) * PRW'(quat_y);
      xz      <= PRW'(quat_x) * PRW'(quat_z);
      yz      <= PRW'(quat_y) * PRW'(quat_z);
      wx      <= PRW'(quat_w) * PRW'(quat_x);
      wy      <= PRW'(quat_w) * PRW'(quat_y);
      wz      <= PRW'(quat_w) * PRW'(quat_z);
      action1 <= action;
      vec1    <= vec;
    end
  end

  always_comb begin
    r00 = ENTRY_HALF - EW'(yy) - EW'(zz);
    r01 = EW'(xy) - EW'(wz);
    r02 = EW'(xz) + EW'(wy);
    r10 = EW'(xy) + EW'(wz);
    r11 = ENTRY_HALF - EW'(xx) - EW'(zz);
    r12 = EW'(yz) - EW'(wx);
    r20 = EW'(xz) - EW'(wy);
    r21 = EW'(yz) + EW'(wx);
    r22 = ENTRY_HALF - EW'(xx) - EW'(yy);
    if (action1 == ACT_EARTH_TO_BODY) begin
      row_x_next = '{m0: r00, m1: r10, m2: r20};
      row_y_next = '{m0: r01, m1: r11, m2: r21};
      row_z_next = '{m0: r02, m1: r12, m2: r22};
    end else begin
      row_x_next = '{m0: r00, m1: r01, m2: r02};
      row_y_next = '{m0: r10, m1: r11, m2: r12};
      row_z_next = '{m0: r20, m1: r21, m2: r22};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      row_x   <= row_x_next;
      row_y   <= row_y_next;
      row_z   <= row_z_next;
      vec_out <= vec1;
    end
  end

endmodule

### hdl/qfr_lane.sv
// ---------------------------------------------------------------------------
// Quaternion frame rotation lane
// One output component: three registered wide products, then a rounded sum
// clipped to the signed 32-bit range with an overflow flag.
// ---------------------------------------------------------------------------
module qfr_lane (
  input  logic                          clk,
  input  qfr_pkg::qfr_en_t              en,
  input  qfr_pkg::qfr_row_t             row,
  input  qfr_pkg::qfr_vec_t             vec,
  output logic signed [qfr_pkg::VW-1:0] res,
  output logic                          sat
);
  import qfr_pkg::*;

  logic signed [PW-1:0]    p0, p1, p2;
  logic signed [SW-1:0]    sum;
  logic signed [QOUTW-1:0] q;
  logic                    ovf;
  logic signed [VW-1:0]    res_next;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      p0 <= PW'(row.m0) * PW'(vec.x);
      p1 <= PW'(row.m1) * PW'(vec.y);
      p2 <= PW'(row.m2) * PW'(vec.z);
    end
  end

  always_comb begin
    sum = SW'(p0) + SW'(p1) + SW'(p2) + ROUND_HALF;
    q   = sum[SW-1:FRAC];
    ovf = !((&q[QOUTW-1:VW-1]) || !(|q[QOUTW-1:VW-1]));
    if (ovf) begin
      res_next = q[QOUTW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      res_next = q[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res <= res_next;
      sat <= ovf;
    end
  end

endmodule

### hdl/quaternion_frame_rotation_unit.sv
// ---------------------------------------------------------------------------
// Quaternion frame rotation unit
// Rotates a Q15.16 vector by the matrix of a Q1.14 quaternion, body to earth
// or earth to body. The unit is fully pipelined: it takes one transfer per
// clock while the output is not stalled, and a result passes through five
// register stages: the two matrix stages, the product and sum stages of the
// three lanes and the output register. Each stage holds its item while the
// next one is full, so bubbles are absorbed and input transfers continue
// while a result waits.
// ---------------------------------------------------------------------------
`include "quaternion_frame_rotation_unit_defines.svh"

module quaternion_frame_rotation_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48],
  // vec_x[95:64], vec_y[127:96], vec_z[159:128]
  input  logic [159:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  m_axis_tdata,
  // saturated[0]
  output logic         m_axis_tuser
);
  import qfr_pkg::*;

  logic     v1, v2, v3, v4;
  logic     rdy1, rdy2, rdy3, rdy4, rdy5;
  qfr_en_t  en;
  qfr_vec_t vec_in, vec_s2;
  qfr_row_t row_x, row_y, row_z;
  logic signed [VW-1:0] res_x, res_y, res_z;
  logic     sat_x, sat_y, sat_z;

  assign rdy5 = !m_axis_tvalid || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_axis_tready = rdy1;
  assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

  assign vec_in = '{x: s_axis_tdata[95:64], y: s_axis_tdata[127:96],
                    z: s_axis_tdata[159:128]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) m_axis_tvalid <= v4;
    end
  end

  qfr_matrix u_matrix (
    .clk     (clk),
    .en      (en),
    .action  (s_axis_tuser),
    .quat_w  (s_axis_tdata[15:0]),
    .quat_x  (s_axis_tdata[31:16]),
    .quat_y  (s_axis_tdata[47:32]),
    .quat_z  (s_axis_tdata[63:48]),
    .vec     (vec_in),
    .row_x   (row_x),
    .row_y   (row_y),
    .row_z   (row_z),
    .vec_out (vec_s2)
  );

  qfr_lane u_lane_x (
    .clk (clk),
    .en  (en),
    .row (row_x),
    .vec (vec_s2),
    .res (res_x),
    .sat (sat_x)
  );

  qfr_lane u_lane_y (
    .clk (clk),
    .en  (en),
    .row (row_y),
    .vec (vec_s2),
    .res (res_y),
    .sat (sat_y)
  );

  qfr_lane u_lane_z (
    .clk (clk),
    .en  (en),
    .row (row_z),
    .vec (vec_s2),
    .res (res_z),
    .sat (sat_z)
  );

  always_ff @(posedge clk) begin
    if (rdy5) begin
      m_axis_tdata <= {res_z, res_y, res_x};
      m_axis_tuser <= sat_x | sat_y | sat_z;
    end
  end

  `QFR_ASSERT_NEXT(a_accept_enters_pipe, s_axis_tvalid && s_axis_tready, v1)
  `QFR_ASSERT_IMPL(a_stall_means_full, !s_axis_tready,
                   v1 && v2 && v3 && v4 && m_axis_tvalid)
  `QFR_ASSERT_IMPL(a_sat_flag_clipped, m_axis_tvalid && m_axis_tuser,
                   (m_axis_tdata[31:0] == 32'h7fffffff) ||
                   (m_axis_tdata[31:0] == 32'h80000000) ||
                   (m_axis_tdata[63:32] == 32'h7fffffff) ||
                   (m_axis_tdata[63:32] == 32'h80000000) ||
                   (m_axis_tdata[95:64] == 32'h7fffffff) ||
                   (m_axis_tdata[95:64] == 32'h80000000))

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quaternion frame rotation unit testbench
// Sends quaternion and vector transfers in both rotation directions, first
// from a table of directed cases and then at random, with random idle cycles
// on both stream sides. Every result is checked field by field, from a queue,
// against the table's expected value or a wide-integer model of the rotation.
// ---------------------------------------------------------------------------
module tb;
  import qfr_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [QW-1:0] Q1 = 16'sd16384;
  localparam logic signed [QW-1:0] QH = 16'sd8192;
  localparam logic signed [QW-1:0] QP = 16'sh7fff;
  localparam logic signed [QW-1:0] QM = 16'sh8000;
  localparam logic signed [QW-1:0] QR = 16'sd11585;
  localparam logic signed [VW-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VW-1:0] VMIN = 32'sh80000000;

  localparam longint UNIT_ENTRY = 64'sd134217728;
  localparam logic signed [79:0] ROUND_BIAS = 80'sd67108864;

  typedef struct {
    logic action;
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic signed [VW-1:0] vx, vy, vz;
  } rot_req_t;

  typedef struct {
    logic signed [VW-1:0] x, y, z;
    logic sat;
  } rot_res_t;

  typedef struct {
    rot_req_t req;
    bit typed;
    rot_res_t res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  rot_res_t expected_rotations[$];
  rot_req_t pend_req;
  rot_res_t pend_res;
  bit       pend_typed = 1'b0;
  bit       quiet = 1'b0;

  int mismatches = 0;
  int rotations_sent = 0;
  int earth_to_body_sent = 0;
  int results_checked = 0;
  int saturations_seen = 0;
  int stall_cycles = 0;

  dir_row_t dir_tab [20];

  always #1 clk = ~clk;

  quaternion_frame_rotation_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Matrix entries are exact in units of 2^-27; sums need up to 67 bits.
  function automatic rot_res_t rotate_vector(input rot_req_t r);
    longint w, x, y, z;
    longint m [3][3];
    logic signed [79:0] v [3];
    logic signed [79:0] acc, coef;
    logic signed [VW-1:0] comp [3];
    rot_res_t res;
    w = longint'(r.qw);
    x = longint'(r.qx);
    y = longint'(r.qy);
    z = longint'(r.qz);
    v[0] = 80'(r.vx);
    v[1] = 80'(r.vy);
    v[2] = 80'(r.vz);
    m[0][0] = UNIT_ENTRY - y * y - z * z;
    m[0][1] = x * y - w * z;
    m[0][2] = x * z + w * y;
    m[1][0] = x * y + w * z;
    m[1][1] = UNIT_ENTRY - x * x - z * z;
    m[1][2] = y * z - w * x;
    m[2][0] = x * z - w * y;
    m[2][1] = y * z + w * x;
    m[2][2] = UNIT_ENTRY - x * x - y * y;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = ROUND_BIAS;
      for (int j = 0; j < 3; j++) begin
        coef = 80'((r.action == ACT_EARTH_TO_BODY) ? m[j][i] : m[i][j]);
        acc = acc + coef * v[j];
      end
      acc = acc >>> FRAC;
      if (acc > 80'sd2147483647) begin
        acc = 80'sd2147483647;
        res.sat = 1'b1;
      end else if (acc < -80'sd2147483648) begin
        acc = -80'sd2147483648;
        res.sat = 1'b1;
      end
      comp[i] = acc[VW-1:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  function automatic logic [QW-1:0] rand_quat_part();
    if ($urandom_range(0, 2) != 0) return QW'($urandom);
    case ($urandom_range(0, 6))
      0: return QM;
      1: return -Q1;
      2: return '1;
      3: return '0;
      4: return 16'sd1;
      5: return Q1;
      default: return QP;
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_vec_part();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 2097152) - 1048576;
      default: begin
        case ($urandom_range(0, 6))
          0: return VMIN;
          1: return VMAX;
          2: return '1;
          3: return '0;
          4: return 32'sd1;
          5: return 32'sd65536;
          default: return -32'sd65536;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_rotation(input rot_req_t r, input bit typed, input rot_res_t res);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    pend_req   = r;
    pend_typed = typed;
    pend_res   = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.vz, r.vy, r.vx, r.qz, r.qy, r.qx, r.qw};
    s_axis_tuser  <= r.action;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= !rst && (quiet || $urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    rot_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (m_axis_tuser === 1'b1) saturations_seen++;
      if (expected_rotations.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_rotations.pop_front();
        if (m_axis_tdata[31:0] !== want.x)
          report_mismatch("out_x", m_axis_tdata[31:0], want.x);
        if (m_axis_tdata[63:32] !== want.y)
          report_mismatch("out_y", m_axis_tdata[63:32], want.y);
        if (m_axis_tdata[95:64] !== want.z)
          report_mismatch("out_z", m_axis_tdata[95:64], want.z);
        if (m_axis_tuser !== want.sat)
          report_mismatch("saturated", 32'(m_axis_tuser), 32'(want.sat));
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      rotations_sent++;
      if (pend_req.action == ACT_EARTH_TO_BODY) earth_to_body_sent++;
      if (pend_typed) expected_rotations.push_back(pend_res);
      else expected_rotations.push_back(rotate_vector(pend_req));
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rot_req_t req;
    rot_res_t none;
    real ra, rb, rc, rd, norm;
    none = '{'0, '0, '0, 1'b0};
    // Identity and zero quaternions pass the vector through; half turns about
    // an axis negate two components; half-scale entries exercise rounding of
    // exact halves; the 120 degree turn about the diagonal permutes the axes.
    dir_tab = '{
      '{'{ACT_BODY_TO_EARTH, Q1, 0, 0, 0, VMAX, VMIN, 0}, 1'b1,
        '{VMAX, VMIN, 0, 1'b0}},
      '{'{ACT_EARTH_TO_BODY, Q1, 0, 0, 0, 1, -1, 12345}, 1'b1,
        '{1, -1, 12345, 1'b0}},
      '{'{ACT_BODY_TO_EARTH, 0, 0, 0, 0, VMIN, VMAX, -1}, 1'b1,
        '{VMIN, VMAX, -1, 1'b0}},
      '{'{ACT_EARTH_TO_BODY, QM, 0, 0, 0, 100, -200, 300}, 1'b1,
        '{100, -200, 300, 1'b0}},
      '{'{ACT_BODY_TO_EARTH, 0, Q1, 0, 0, 7, VMIN, VMAX}, 1'b1,
        '{7, VMAX, 32'sh80000001, 1'b1}},
      '{'{ACT_EARTH_TO_BODY, 0, Q1, 0, 0, 1, 2, 3}, 1'b1,
        '{1, -2, -3, 1'b0}},
      '{'{ACT_BODY_TO_EARTH, 0, 0, 0, Q1, VMIN, 5, 6}, 1'b1,
        '{VMAX, -5, 6, 1'b1}},
      '{'{ACT_EARTH_TO_BODY, 0, 0, Q1, 0, 10, 20, VMIN}, 1'b1,
        '{-10, 20, VMAX, 1'b1}},
      '{'{ACT_BODY_TO_EARTH, 0, QH, 0, 0, 5, 1, -1}, 1'b1,
        '{5, 1, 0, 1'b0}},
      '{'{ACT_EARTH_TO_BODY, 0, QH, 0, 0, 0, 3, -3}, 1'b1,
        '{0, 2, -1, 1'b0}},
      '{'{ACT_BODY_TO_EARTH, QH, QH, QH, QH, 1, 2, -3}, 1'b1,
        '{-3, 1, 2, 1'b0}},
      '{'{ACT_EARTH_TO_BODY, QH, QH, QH, QH, VMAX, VMIN, 0}, 1'b1,
        '{VMIN, 0, VMAX, 1'b0}},
      '{'{ACT_BODY_TO_EARTH, QR, 0, 0, QR, 65536, 0, 0}, 1'b0, none},
      '{'{ACT_EARTH_TO_BODY, QR, 0, 0, QR, 65536, -65536, VMAX}, 1'b0, none},
      '{'{ACT_BODY_TO_EARTH, QM, QM, QM, QM, VMAX, VMAX, VMAX}, 1'b0, none},
      '{'{ACT_EARTH_TO_BODY, QP, QP, QP, QP, VMIN, VMIN, VMIN}, 1'b0, none},
      '{'{ACT_EARTH_TO_BODY, QM, QM, QM, QM, VMIN, VMAX, VMIN}, 1'b0, none},
      '{'{ACT_BODY_TO_EARTH, QP, QM, QP, QM, VMAX, VMIN, VMAX}, 1'b0, none},
      '{'{ACT_BODY_TO_EARTH, -QR, QR, 0, 0, 65536, 65536, 65536}, 1'b0, none},
      '{'{ACT_EARTH_TO_BODY, 0, 0, -Q1, 0, 123456, -654321, 999}, 1'b0, none}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_rotation(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    // Most random transfers carry a near-unit quaternion; the rest use raw
    // or extreme components, which makes saturation common.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 1000);
      req.action = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 55) begin
        ra = real'(int'($urandom_range(0, 2000)) - 1000);
        rb = real'(int'($urandom_range(0, 2000)) - 1000);
        rc = real'(int'($urandom_range(0, 2000)) - 1000);
        rd = real'(int'($urandom_range(0, 2000)) - 1000);
        norm = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
        if (norm < 1.0) norm = 1.0;
        req.qw = QW'($rtoi(ra / norm * 16384.0));
        req.qx = QW'($rtoi(rb / norm * 16384.0));
        req.qy = QW'($rtoi(rc / norm * 16384.0));
        req.qz = QW'($rtoi(rd / norm * 16384.0));
      end else begin
        req.qw = rand_quat_part();
        req.qx = rand_quat_part();
        req.qy = rand_quat_part();
        req.qz = rand_quat_part();
      end
      req.vx = rand_vec_part();
      req.vy = rand_vec_part();
      req.vz = rand_vec_part();
      send_rotation(req, 1'b0, none);
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d rotations, %0d of them earth to body, directed and random.",
             rotations_sent, earth_to_body_sent);
    $display("Checked %0d results, %0d of them saturated; %0d mismatches.",
             results_checked, saturations_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
